/* hw/rtl/isbnvn_pkg.sv */
// shared types, codes and small arithmetic helpers for the isbn validator
package isbnvn_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 44;
  localparam int unsigned CountW = 4;

  localparam logic [CharW-1:0] ChHyphen = 8'h2D;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChNine   = 8'h39;
  localparam logic [CharW-1:0] ChUpperX = 8'h58;
  localparam logic [CharW-1:0] ChLowerX = 8'h78;

  localparam logic [CountW-1:0] MaxChars   = 4'd13;
  localparam logic [CountW-1:0] Isbn10Len  = 4'd10;
  localparam logic [CountW-1:0] Isbn13Len  = 4'd13;
  localparam logic [CountW-1:0] CheckPos10 = 4'd9;

  // weights of the 978 prefix: 9*1 + 7*3 + 8*1
  localparam logic [7:0]        PrefixCheckSum = 8'd38;
  localparam logic [ValueW-1:0] PrefixValue    = 44'd978;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_CHAR = 2'd1,
    ERR_TOO_MANY = 2'd2
  } early_err_e;

  typedef enum logic [2:0] {
    OUT_ISBN10_OK  = 3'd0,
    OUT_ISBN13_OK  = 3'd1,
    OUT_BAD_CHAR   = 3'd2,
    OUT_TOO_MANY   = 3'd3,
    OUT_BAD_LENGTH = 3'd4,
    OUT_MISPLACE_X = 3'd5,
    OUT_CHECKSUM   = 3'd6
  } outcome_e;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [3:0]        res_mod11;   // weighted isbn-10 sum, kept reduced mod 11
    logic [7:0]        sum_alt;     // 1/3 weighted isbn-13 sum
    logic [7:0]        sum_conv;    // 1/3 weighted sum of the converted number
    logic [ValueW-1:0] dec_acc;
    logic [ValueW-1:0] conv_acc;
    logic [1:0]        x_flags;     // bit0: x off the check place, bit1: x on it
    early_err_e        err;
  } state_t;

  typedef struct packed {
    logic              valid_res;
    logic [ValueW-1:0] value;
    outcome_e          outcome;
  } result_t;

  // x mod 11 for x < 111, via reciprocal 187/2048
  function automatic logic [3:0] mod11_7(input logic [6:0] x);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [7:0]  rem;
    prod = 15'(x) * 15'd187;
    q    = prod[14:11];
    rem  = 8'(x) - 8'(q) * 8'd11;
    return rem[3:0];
  endfunction

  // x mod 10 for an 8-bit x, via reciprocal 205/2048
  function automatic logic [3:0] mod10_8(input logic [7:0] x);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [8:0]  rem;
    prod = 16'(x) * 16'd205;
    q    = prod[15:11];
    rem  = 9'(x) - 9'(q) * 9'd10;
    return rem[3:0];
  endfunction

  function automatic logic [ValueW-1:0] times10_plus(input logic [ValueW-1:0] acc,
                                                      input logic [3:0] d);
    return {acc[ValueW-4:0], 3'b000} + {acc[ValueW-2:0], 1'b0} + ValueW'(d);
  endfunction

endpackage

/* hw/rtl/isbnvn_step.sv */
// one character of state update plus the end-of-string verdict
module isbnvn_step (
  input  isbnvn_pkg::state_t               cur_i,
  input  logic [isbnvn_pkg::CharW-1:0]     char_code_i,
  output isbnvn_pkg::state_t               nxt_o,
  output isbnvn_pkg::result_t              res_o
);

  logic              is_sep, is_digit, is_x;
  logic [3:0]        v;
  logic [3:0]        i;
  logic [3:0]        w11;
  logic [7:0]        prod11;
  logic [6:0]        sum11;
  logic [7:0]        alt_term, conv_term;
  logic [3:0]        conv_mod, chk;

  assign i        = cur_i.count;
  assign is_sep   = (char_code_i == isbnvn_pkg::ChHyphen) || (char_code_i == isbnvn_pkg::ChSpace);
  assign is_digit = (char_code_i >= isbnvn_pkg::ChZero) && (char_code_i <= isbnvn_pkg::ChNine);
  assign is_x     = (char_code_i == isbnvn_pkg::ChUpperX) || (char_code_i == isbnvn_pkg::ChLowerX);
  assign v        = is_x ? 4'd10 : 4'(char_code_i - isbnvn_pkg::ChZero);

  assign w11       = 4'd10 - i;
  assign prod11    = 8'(v) * 8'(w11);
  assign sum11     = 7'(cur_i.res_mod11) + 7'(prod11);
  assign alt_term  = i[0] ? 8'(v) * 8'd3 : 8'(v);
  assign conv_term = i[0] ? 8'(v) : 8'(v) * 8'd3;

  always_comb begin
    nxt_o = cur_i;
    if (!is_sep && (cur_i.err == isbnvn_pkg::ERR_NONE)) begin
      if (i >= isbnvn_pkg::MaxChars) begin
        nxt_o.err = isbnvn_pkg::ERR_TOO_MANY;
      end else if (!is_digit && !is_x) begin
        nxt_o.err = isbnvn_pkg::ERR_BAD_CHAR;
      end else begin
        if (is_x) begin
          if (i == isbnvn_pkg::CheckPos10) begin
            nxt_o.x_flags[1] = 1'b1;
          end else begin
            nxt_o.x_flags[0] = 1'b1;
          end
        end
        if (i < isbnvn_pkg::Isbn10Len) begin
          nxt_o.res_mod11 = isbnvn_pkg::mod11_7(sum11);
        end
        if (!is_x) begin
          nxt_o.sum_alt = cur_i.sum_alt + alt_term;
          nxt_o.dec_acc = isbnvn_pkg::times10_plus(cur_i.dec_acc, v);
          if (i < isbnvn_pkg::CheckPos10) begin
            nxt_o.sum_conv = cur_i.sum_conv + conv_term;
            nxt_o.conv_acc = isbnvn_pkg::times10_plus(cur_i.conv_acc, v);
          end
        end
        nxt_o.count = i + 4'd1;
      end
    end
  end

  // isbn-13 check digit of the converted number
  assign conv_mod = isbnvn_pkg::mod10_8(nxt_o.sum_conv);
  assign chk      = (conv_mod == 4'd0) ? 4'd0 : 4'd10 - conv_mod;

  always_comb begin
    res_o.value = '0;
    priority if (nxt_o.err == isbnvn_pkg::ERR_BAD_CHAR) begin
      res_o.outcome = isbnvn_pkg::OUT_BAD_CHAR;
    end else if (nxt_o.err == isbnvn_pkg::ERR_TOO_MANY) begin
      res_o.outcome = isbnvn_pkg::OUT_TOO_MANY;
    end else if (nxt_o.count == isbnvn_pkg::Isbn10Len) begin
      if (nxt_o.x_flags[0]) begin
        res_o.outcome = isbnvn_pkg::OUT_MISPLACE_X;
      end else if (nxt_o.res_mod11 != 4'd0) begin
        res_o.outcome = isbnvn_pkg::OUT_CHECKSUM;
      end else begin
        res_o.outcome = isbnvn_pkg::OUT_ISBN10_OK;
        res_o.value   = isbnvn_pkg::times10_plus(nxt_o.conv_acc, chk);
      end
    end else if (nxt_o.count == isbnvn_pkg::Isbn13Len) begin
      if (nxt_o.x_flags != 2'b00) begin
        res_o.outcome = isbnvn_pkg::OUT_MISPLACE_X;
      end else if (isbnvn_pkg::mod10_8(nxt_o.sum_alt) != 4'd0) begin
        res_o.outcome = isbnvn_pkg::OUT_CHECKSUM;
      end else begin
        res_o.outcome = isbnvn_pkg::OUT_ISBN13_OK;
        res_o.value   = nxt_o.dec_acc;
      end
    end else begin
      res_o.outcome = isbnvn_pkg::OUT_BAD_LENGTH;
    end
    res_o.valid_res = (res_o.outcome == isbnvn_pkg::OUT_ISBN10_OK) ||
                      (res_o.outcome == isbnvn_pkg::OUT_ISBN13_OK);
  end

endmodule

/* hw/rtl/isbn_validate_normalize.sv */
// Streaming ISBN-10/ISBN-13 validator and normalizer. One ASCII byte is
// taken per beat, one every clock cycle; hyphens and spaces are skipped. The
// beat marked is_last yields one result beat: it is captured in the input
// register, then the state update and verdict are registered into the output
// register, and the running state clears for the next string.
// Valid ISBN-10s come out converted to ISBN-13 with the 978 prefix. Throughput
// is one byte per cycle, set by the combinational state update; out_ready_i low
// stalls the input only when a last byte is waiting and the output register is
// full.
module isbn_validate_normalize (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [isbnvn_pkg::CharW-1:0]        char_code_i,
  input  logic                                is_last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                valid_res_o,
  output logic [isbnvn_pkg::ValueW-1:0]       isbn13_value_o,
  output logic [2:0]                          outcome_o
);

  localparam isbnvn_pkg::state_t StateReset = '{
    count:     '0,
    res_mod11: '0,
    sum_alt:   '0,
    sum_conv:  isbnvn_pkg::PrefixCheckSum,
    dec_acc:   '0,
    conv_acc:  isbnvn_pkg::PrefixValue,
    x_flags:   '0,
    err:       isbnvn_pkg::ERR_NONE
  };

  logic                         in_vld_q;
  logic [isbnvn_pkg::CharW-1:0] char_q;
  logic                         last_q;
  logic                         step_take;
  logic                         out_vld_q;
  isbnvn_pkg::state_t           state_q, state_nxt;
  isbnvn_pkg::result_t          res_d, res_q;

  // a non-last beat never needs the output register
  assign step_take  = in_vld_q && (!last_q || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step_take;

  isbnvn_step u_step (
    .cur_i       (state_q),
    .char_code_i (char_q),
    .nxt_o       (state_nxt),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_code_i;
      last_q <= is_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (step_take) begin
      state_q <= last_q ? StateReset : state_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step_take && last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_take && last_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign valid_res_o    = res_q.valid_res;
  assign isbn13_value_o = res_q.value;
  assign outcome_o      = res_q.outcome;

endmodule
